// ===== sv/mlp_pkg.sv =====
package mlp_pkg;

    localparam int HIDDEN_COUNT  = 10;
    localparam int INPUT_COUNT   = 3;
    localparam int COEF_WIDTH    = 24;
    localparam int SIGMOID_DEPTH = 256;
    localparam int SEED_COUNT    = 10;

    localparam int FRAC_W    = COEF_WIDTH + 6;
    localparam int BIAS_FRAC = COEF_WIDTH - 4;
    localparam int IDX_W     = $clog2(SIGMOID_DEPTH);
    localparam int SIG_W     = 16;
    localparam int OUT_W     = 36;

    localparam int AXIS_W  = 20;
    localparam int ECC_W   = 16;
    localparam int THETA_W = 16;

    localparam int P0_W   = COEF_WIDTH + AXIS_W + 1;
    localparam int P1_W   = COEF_WIDTH + ECC_W + 1;
    localparam int P2_W   = COEF_WIDTH + THETA_W;
    localparam int ACC_W  = FRAC_W + 18;
    localparam int OP_W   = COEF_WIDTH + SIG_W + 1;
    localparam int OSUM_W = OP_W + $clog2(HIDDEN_COUNT + 1) + 1;
    localparam int RES_W  = OUT_W + 4;

    localparam logic [OUT_W-1:0] OUTPUT_BIAS = OUT_W'(64'd384400 << 16);

    typedef logic signed [COEF_WIDTH-1:0] coef_t;
    typedef coef_t coef_hw_t [HIDDEN_COUNT*INPUT_COUNT];
    typedef coef_t coef_h_t [HIDDEN_COUNT];
    typedef logic [SIG_W-1:0] sig_table_t [SIGMOID_DEPTH];

    typedef int seed_hw_t [SEED_COUNT*3];
    typedef int seed_h_t [SEED_COUNT];

    localparam seed_hw_t SEED_HW = '{
        45, -12, 32, 52, 31, -18, -27, 58, 41, 63, 11, 5, 44, -21, 23,
        49, 7, 37, 30, 45, -11, 18, 54, 9, -12, 39, 26, 57, 29, -22};
    localparam seed_h_t SEED_HB = '{12, -5, 3, 8, -2, 4, 6, -1, 11, 7};
    localparam seed_h_t SEED_OW = '{23, 28, -11, 19, 21, 25, 17, -9, 15, 26};

    function automatic longint unsigned udiv(longint unsigned n, longint unsigned d);
        longint unsigned q;
        logic [64:0] rem;
        q   = '0;
        rem = '0;
        for (int i = 63; i >= 0; i--) begin
            rem = {rem[63:0], n[i]};
            if (rem >= {1'b0, d}) begin
                rem  = rem - {1'b0, d};
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic longint signed q_sign(int n, longint unsigned q);
        return (n < 0) ? -longint'(q) : longint'(q);
    endfunction

    function automatic coef_hw_t build_hw();
        coef_hw_t r;
        longint unsigned mag;
        for (int h = 0; h < HIDDEN_COUNT; h++) begin
            for (int j = 0; j < INPUT_COUNT; j++) begin
                r[h*INPUT_COUNT+j] = '0;
                if (h < SEED_COUNT && j < 3) begin
                    mag = longint'(SEED_HW[h*3+j] < 0 ? -SEED_HW[h*3+j] : SEED_HW[h*3+j]);
                    r[h*INPUT_COUNT+j] = COEF_WIDTH'(q_sign(SEED_HW[h*3+j],
                        udiv((mag << FRAC_W) + 64'd50000, 64'd100000)));
                end
            end
        end
        return r;
    endfunction

    function automatic coef_h_t build_hb();
        coef_h_t r;
        longint unsigned mag;
        for (int h = 0; h < HIDDEN_COUNT; h++) begin
            r[h] = '0;
            if (h < SEED_COUNT) begin
                mag = longint'(SEED_HB[h] < 0 ? -SEED_HB[h] : SEED_HB[h]);
                r[h] = COEF_WIDTH'(q_sign(SEED_HB[h],
                    udiv((mag << BIAS_FRAC) + 64'd50, 64'd100)));
            end
        end
        return r;
    endfunction

    function automatic coef_h_t build_ow();
        coef_h_t r;
        longint unsigned mag;
        for (int h = 0; h < HIDDEN_COUNT; h++) begin
            r[h] = '0;
            if (h < SEED_COUNT) begin
                mag = longint'(SEED_OW[h] < 0 ? -SEED_OW[h] : SEED_OW[h]);
                r[h] = COEF_WIDTH'(q_sign(SEED_OW[h],
                    udiv((mag << FRAC_W) + 64'd5000, 64'd10000)));
            end
        end
        return r;
    endfunction

    function automatic longint unsigned exp_neg16(longint unsigned r);
        longint signed sum;
        longint unsigned term;
        longint unsigned y;
        sum  = 64'sd1 <<< 31;
        term = 64'd1 << 31;
        for (int k = 1; k <= 16; k++) begin
            term = udiv((term * r) >> 31, longint'(k));
            if ((k & 1) == 1)
                sum = sum - longint'(term);
            else
                sum = sum + longint'(term);
        end
        y = longint'(sum);
        for (int i = 0; i < 4; i++)
            y = (y * y + (64'd1 << 30)) >> 31;
        return y;
    endfunction

    function automatic sig_table_t build_sig();
        sig_table_t t;
        longint signed num;
        longint unsigned mag;
        longint unsigned r;
        longint unsigned e;
        longint unsigned den;
        longint unsigned s;
        for (int i = 0; i < SIGMOID_DEPTH; i++) begin
            num = 2 * longint'(i) - SIGMOID_DEPTH;
            mag = (num < 0) ? -num : num;
            r   = udiv((mag << 31) + longint'(SIGMOID_DEPTH), 2 * longint'(SIGMOID_DEPTH));
            e   = exp_neg16(r);
            den = (64'd1 << 31) + e;
            if (num >= 0)
                s = udiv((64'd1 << 47) + (den >> 1), den);
            else
                s = udiv((e << 16) + (den >> 1), den);
            t[i] = SIG_W'(s);
        end
        return t;
    endfunction

    localparam coef_hw_t   HIDDEN_WEIGHT = build_hw();
    localparam coef_h_t    HIDDEN_BIAS   = build_hb();
    localparam coef_h_t    OUTPUT_WEIGHT = build_ow();
    localparam sig_table_t SIGMOID_TABLE = build_sig();

endpackage

// ===== sv/mlp_sigmoid_inference_3_10_1.sv =====
// Forward pass of a 3-10-1 sigmoid network: six-stage pipeline with one lane per hidden
// neuron (input products, hidden sum, sigmoid table lookup, output product, partial sums,
// bias add with rounding and saturation). One word enters per cycle while the output is not
// stalled; m_valid follows once the word has passed all six register stages. A stall on
// m_ready holds the whole pipeline.
module mlp_sigmoid_inference_3_10_1 (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [mlp_pkg::AXIS_W-1:0]           s_semi_major_axis_km,
    input  logic [mlp_pkg::ECC_W-1:0]            s_eccentricity_q16,
    input  logic signed [mlp_pkg::THETA_W-1:0]   s_theta_q12,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [mlp_pkg::OUT_W-1:0]            m_distance_q16
);

    localparam int H     = mlp_pkg::HIDDEN_COUNT;
    localparam int HALF  = H / 2;
    localparam int NSTG  = 6;
    localparam int ACC_W = mlp_pkg::ACC_W;

    localparam logic signed [ACC_W-1:0] LIM = ACC_W'(64'sd1 <<< (mlp_pkg::FRAC_W + 3));

    logic                                   adv;
    logic [NSTG-1:0]                        v_reg;

    logic signed [mlp_pkg::P0_W-1:0]        p0_reg [H];
    logic signed [mlp_pkg::P1_W-1:0]        p1_reg [H];
    logic signed [mlp_pkg::P2_W-1:0]        p2_reg [H];
    logic signed [ACC_W-1:0]                acc_next [H];
    logic signed [ACC_W-1:0]                acc_reg [H];
    logic [mlp_pkg::IDX_W-1:0]              idx_next [H];
    logic [mlp_pkg::SIG_W-1:0]              sig_reg [H];
    logic signed [mlp_pkg::OP_W-1:0]        op_reg [H];
    logic signed [mlp_pkg::OSUM_W-1:0]      lo_next, hi_next;
    logic signed [mlp_pkg::OSUM_W-1:0]      lo_reg, hi_reg;
    logic signed [mlp_pkg::OSUM_W-1:0]      osum;
    logic signed [mlp_pkg::RES_W-1:0]       res;
    logic [mlp_pkg::OUT_W-1:0]              dist_next;
    logic [mlp_pkg::OUT_W-1:0]              dist_reg;

    assign adv     = !v_reg[NSTG-1] || m_ready;
    assign s_ready = adv;
    assign m_valid = v_reg[NSTG-1];
    assign m_distance_q16 = dist_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (adv) begin
            v_reg <= {v_reg[NSTG-2:0], s_valid};
        end
    end

    always_comb begin
        for (int h = 0; h < H; h++) begin
            acc_next[h] = ACC_W'(mlp_pkg::HIDDEN_BIAS[h]) <<< 10;
            acc_next[h] = acc_next[h] + ACC_W'(p0_reg[h]);
            acc_next[h] = acc_next[h] + ACC_W'(p1_reg[h] >>> 16);
            acc_next[h] = acc_next[h] + ACC_W'(p2_reg[h] >>> 12);
        end
    end

    always_comb begin
        logic signed [ACC_W-1:0] off;
        for (int h = 0; h < H; h++) begin
            off = acc_reg[h] + LIM;
            if (acc_reg[h] < -LIM) begin
                idx_next[h] = '0;
            end else if (acc_reg[h] >= LIM) begin
                idx_next[h] = '1;
            end else begin
                idx_next[h] = off[mlp_pkg::FRAC_W+3 -: mlp_pkg::IDX_W];
            end
        end
    end

    always_comb begin
        lo_next = '0;
        hi_next = '0;
        for (int h = 0; h < HALF; h++)
            lo_next = lo_next + mlp_pkg::OSUM_W'(op_reg[h]);
        for (int h = HALF; h < H; h++)
            hi_next = hi_next + mlp_pkg::OSUM_W'(op_reg[h]);
    end

    always_comb begin
        osum = lo_reg + hi_reg + (mlp_pkg::OSUM_W'(1) <<< (mlp_pkg::FRAC_W - 1));
        res  = $signed({4'd0, mlp_pkg::OUTPUT_BIAS})
             + mlp_pkg::RES_W'(osum >>> mlp_pkg::FRAC_W);
        priority if (res < 0) begin
            dist_next = '0;
        end else if (res[mlp_pkg::RES_W-1:mlp_pkg::OUT_W] != '0) begin
            dist_next = '1;
        end else begin
            dist_next = res[mlp_pkg::OUT_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int h = 0; h < H; h++) begin
                p0_reg[h] <= mlp_pkg::HIDDEN_WEIGHT[h*mlp_pkg::INPUT_COUNT]
                           * $signed({1'b0, s_semi_major_axis_km});
                p1_reg[h] <= mlp_pkg::HIDDEN_WEIGHT[h*mlp_pkg::INPUT_COUNT+1]
                           * $signed({1'b0, s_eccentricity_q16});
                p2_reg[h] <= mlp_pkg::HIDDEN_WEIGHT[h*mlp_pkg::INPUT_COUNT+2] * s_theta_q12;
                acc_reg[h] <= acc_next[h];
                sig_reg[h] <= mlp_pkg::SIGMOID_TABLE[idx_next[h]];
                op_reg[h]  <= mlp_pkg::OUTPUT_WEIGHT[h] * $signed({1'b0, sig_reg[h]});
            end
            lo_reg   <= lo_next;
            hi_reg   <= hi_next;
            dist_reg <= dist_next;
        end
    end

    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> v_reg == '0)
        else $error("pipeline valid bits not cleared by reset");
    a_accept_enters: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> v_reg[0])
        else $error("accepted word missing from first stage");
    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(v_reg) && $stable(dist_reg))
        else $error("pipeline moved during output stall");

endmodule
